/* hdl/psp_pkg.sv */
// Shared constants, confidence codes and control structs for the page stride prefetcher.
// Used by psp_ctrl, psp_datapath and page_stride_prefetcher_unit; depends on nothing.
package psp_pkg;

    localparam int ADDR_W = 64;

    localparam int TABLE_ENTRIES_DEF = 1024;
    localparam int DEGREE_DEF        = 5;
    localparam int PAGE_SHIFT_DEF    = 12;

    localparam int CONF_W = 2;
    localparam logic [CONF_W-1:0] CONF_INITIAL   = 2'd0;
    localparam logic [CONF_W-1:0] CONF_TRANSIENT = 2'd1;
    localparam logic [CONF_W-1:0] CONF_STEADY    = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_step;   // write one zero entry during the clearing pass
        logic capture;    // latch the request and start the table read
        logic update;     // write the trained entry back
        logic out_first;  // load the first prefetch page
        logic out_next;   // advance the prefetch page by one stride
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;   // clearing pass is at the last entry
        logic ignore;     // request is a hit or training is off
        logic emit;       // looked-up entry fires a prefetch run
    } t_dp_status;

endpackage

/* hdl/page_stride_prefetcher_unit.sv */
// Top level of the page stride prefetcher.
// Instantiates psp_ctrl and psp_datapath; depends on psp_pkg.
//
// Usage:
//   Requests enter on the s_axis channel: tdata holds the access address and the
//   instruction pointer, tuser the hit flag. Prefetch page addresses leave on the
//   m_axis channel, tlast marking the final address of a run of DEGREE.
//   The training_enabled register is written through i_cfg_wr_en / i_cfg_wr_data
//   and resets to 0; while it is 0, and for hits, requests are taken and dropped.
//   A dropped request is taken while the controller stays idle. A miss reads the
//   table in the accept cycle and writes it back in the next, so no new request
//   is taken until the single read-modify-write of the table RAM is done. A miss
//   that fires a run then emits DEGREE prefetches from the output register, the
//   write-back state loading the first one and setting it valid.
//   After reset the table is cleared, one entry per cycle; tready stays low
//   meanwhile, configuration writes are taken anyway.
//   When the receiver stalls, the current prefetch holds and no new request is
//   taken until the run is delivered. TABLE_ENTRIES must be a power of two.
module page_stride_prefetcher_unit #(
    parameter int TABLE_ENTRIES = psp_pkg::TABLE_ENTRIES_DEF,
    parameter int DEGREE        = psp_pkg::DEGREE_DEF,
    parameter int PAGE_SHIFT    = psp_pkg::PAGE_SHIFT_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic                         i_cfg_wr_data,   // training_enabled
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    input  logic [2*psp_pkg::ADDR_W-1:0] i_s_axis_tdata,  // access_addr, instr_ptr
    input  logic                         i_s_axis_tuser,  // was_hit
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    output logic [psp_pkg::ADDR_W-1:0]   o_m_axis_tdata,  // prefetch_addr
    output logic                         o_m_axis_tlast   // last_of_run
);

    psp_pkg::t_dp_cmd    cmd;
    psp_pkg::t_dp_status status;

    psp_ctrl #(
        .DEGREE (DEGREE)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_status        (status),
        .o_cmd           (cmd)
    );

    psp_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .PAGE_SHIFT    (PAGE_SHIFT)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_access_addr   (i_s_axis_tdata[psp_pkg::ADDR_W-1:0]),
        .i_instr_ptr     (i_s_axis_tdata[2*psp_pkg::ADDR_W-1:psp_pkg::ADDR_W]),
        .i_was_hit       (i_s_axis_tuser),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_prefetch_addr (o_m_axis_tdata)
    );

endmodule

/* hdl/psp_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Used for the reference prediction table; depends on nothing.
module psp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/psp_datapath.sv */
// Datapath of the page stride prefetcher: request registers, table RAM, training
// logic and prefetch address generator. Depends on psp_pkg and psp_ram.
module psp_datapath #(
    parameter int TABLE_ENTRIES = psp_pkg::TABLE_ENTRIES_DEF,
    parameter int PAGE_SHIFT    = psp_pkg::PAGE_SHIFT_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic                       i_cfg_wr_data,
    input  logic [psp_pkg::ADDR_W-1:0] i_access_addr,
    input  logic [psp_pkg::ADDR_W-1:0] i_instr_ptr,
    input  logic                       i_was_hit,
    input  psp_pkg::t_dp_cmd           i_cmd,
    output psp_pkg::t_dp_status        o_status,
    output logic [psp_pkg::ADDR_W-1:0] o_prefetch_addr
);

    // TABLE_ENTRIES must be a power of two (unchecked); index, tag are pointer bits.
    localparam int IDX_W    = $clog2(TABLE_ENTRIES);
    localparam int TAG_W    = psp_pkg::ADDR_W - IDX_W;
    localparam int PAGE_W   = psp_pkg::ADDR_W - PAGE_SHIFT;
    localparam int STRIDE_W = PAGE_W + 1;
    localparam int CONF_W   = psp_pkg::CONF_W;
    localparam int ENTRY_W  = 1 + TAG_W + PAGE_W + STRIDE_W + CONF_W;

    logic               r_train;
    logic [IDX_W-1:0]   r_clr_addr;
    logic [IDX_W-1:0]   r_idx;
    logic [TAG_W-1:0]   r_tag;
    logic [PAGE_W-1:0]  r_page;
    logic [PAGE_W-1:0]  r_opage;
    logic [PAGE_W-1:0]  r_ostride;

    logic [ENTRY_W-1:0] rd_word;
    logic [ENTRY_W-1:0] wr_word;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;

    logic                rd_valid;
    logic [TAG_W-1:0]    rd_tag;
    logic [PAGE_W-1:0]   rd_last;
    logic [STRIDE_W-1:0] rd_stride;
    logic [CONF_W-1:0]   rd_conf;

    logic                tag_hit;
    logic [STRIDE_W-1:0] stride_now;
    logic                stride_zero;
    logic                stride_match;
    logic [STRIDE_W-1:0] nx_stride;
    logic [CONF_W-1:0]   nx_conf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_train    <= 1'b0;
            r_clr_addr <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_train <= i_cfg_wr_data;
            end
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_idx  <= i_instr_ptr[IDX_W-1:0];
            r_tag  <= i_instr_ptr[psp_pkg::ADDR_W-1:IDX_W];
            r_page <= i_access_addr[psp_pkg::ADDR_W-1:PAGE_SHIFT];
        end
        if (i_cmd.out_first) begin
            r_opage   <= r_page + rd_stride[PAGE_W-1:0];
            r_ostride <= rd_stride[PAGE_W-1:0];
        end else if (i_cmd.out_next) begin
            r_opage <= r_opage + r_ostride;
        end
    end

    assign {rd_valid, rd_tag, rd_last, rd_stride, rd_conf} = rd_word;

    // The page difference of two PAGE_W-bit pages fits a signed PAGE_W+1 bit stride.
    assign tag_hit      = rd_valid && (rd_tag == r_tag);
    assign stride_now   = {1'b0, r_page} - {1'b0, rd_last};
    assign stride_zero  = (stride_now == '0);
    assign stride_match = (stride_now == rd_stride);

    always_comb begin
        nx_stride = rd_stride;
        nx_conf   = rd_conf;
        unique case (rd_conf)
            psp_pkg::CONF_STEADY: begin
                if (!stride_match) begin
                    nx_conf = psp_pkg::CONF_INITIAL;
                end
            end
            psp_pkg::CONF_TRANSIENT: begin
                if (stride_match) begin
                    nx_conf = psp_pkg::CONF_STEADY;
                end else begin
                    nx_conf   = psp_pkg::CONF_INITIAL;
                    nx_stride = stride_now;
                end
            end
            default: begin
                if (stride_match) begin
                    nx_conf = psp_pkg::CONF_STEADY;
                end else begin
                    nx_conf   = psp_pkg::CONF_TRANSIENT;
                    nx_stride = stride_now;
                end
            end
        endcase
    end

    always_comb begin
        if (i_cmd.clr_step) begin
            wr_word = '0;
        end else if (!tag_hit) begin
            wr_word = {1'b1, r_tag, r_page, {STRIDE_W{1'b0}}, psp_pkg::CONF_INITIAL};
        end else if (stride_zero) begin
            wr_word = rd_word;
        end else begin
            wr_word = {1'b1, r_tag, r_page, nx_stride, nx_conf};
        end
    end

    assign ram_we    = i_cmd.clr_step || i_cmd.update;
    assign ram_waddr = i_cmd.clr_step ? r_clr_addr : r_idx;

    psp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (wr_word),
        .i_re    (i_cmd.capture),
        .i_raddr (i_instr_ptr[IDX_W-1:0]),
        .o_rdata (rd_word)
    );

    assign o_status.clr_last = (r_clr_addr == {IDX_W{1'b1}});
    assign o_status.ignore   = i_was_hit || !r_train;
    assign o_status.emit     = tag_hit && !stride_zero && stride_match
                               && (rd_conf == psp_pkg::CONF_STEADY);

    assign o_prefetch_addr = {r_opage, {PAGE_SHIFT{1'b0}}};

endmodule

/* hdl/psp_ctrl.sv */
// Controller of the page stride prefetcher: clearing pass, request handshake,
// table update sequencing and prefetch run counting. Depends on psp_pkg.
module psp_ctrl #(
    parameter int DEGREE = psp_pkg::DEGREE_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    output logic                o_m_axis_tlast,
    input  psp_pkg::t_dp_status i_status,
    output psp_pkg::t_dp_cmd    o_cmd
);

    localparam int CNT_W = $clog2(DEGREE + 1);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_UPD   = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0]       r_state;
    logic [1:0]       n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             r_last;
    logic             n_last;
    logic             in_acc;
    logic             out_acc;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign out_acc         = r_out_valid && i_m_axis_tready;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_last      = r_last;
        o_cmd       = '0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_acc && !i_status.ignore) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_UPD;
                end
            end
            ST_UPD: begin
                o_cmd.update = 1'b1;
                if (i_status.emit) begin
                    o_cmd.out_first = 1'b1;
                    n_out_valid     = 1'b1;
                    n_cnt           = CNT_W'(1);
                    n_last          = (DEGREE == 1);
                    n_state         = ST_EMIT;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                if (out_acc) begin
                    if (r_cnt == CNT_W'(DEGREE)) begin
                        n_out_valid = 1'b0;
                        n_last      = 1'b0;
                        n_state     = ST_IDLE;
                    end else begin
                        o_cmd.out_next = 1'b1;
                        n_cnt          = r_cnt + 1'b1;
                        n_last         = (r_cnt + 1'b1 == CNT_W'(DEGREE));
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_last      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            r_last      <= n_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tlast  = r_last;

    a_valid_only_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_state == ST_EMIT))
        else $error("prefetch shown outside the emit state");

    a_last_at_degree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_last |-> (r_cnt == CNT_W'(DEGREE)))
        else $error("last flag before the final prefetch of the run");

    a_update_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPD) |-> $past(in_acc))
        else $error("table update without an accepted request");

endmodule
